>>> hdl/cau_pkg.sv
// Shared types for the complex arithmetic unit.
// No dependencies; used by the top level, cau_front and cau_sat.
`default_nettype none
package cau_pkg;

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_DIV = 2'd3
  } cmd_t;

  typedef struct packed {
    logic vld;
    cmd_t cmd;
    logic dz;
  } ctl_t;

  typedef struct packed {
    logic neg;
    logic hi;
  } lane_t;

endpackage
`default_nettype wire

>>> hdl/complex_arithmetic_unit.sv
// Top level of the complex arithmetic unit: front end, divider pipeline, output stage.
// Depends on cau_pkg, cau_front, cau_div_step and cau_sat.
//
// The unit takes one word per clock cycle and never stalls: busy is always low. Every
// word, whatever its command, leaves the unit on out_valid for one cycle. The divider
// resolves one quotient bit per pipeline stage for WORD_BITS + 1 stages, after four
// stages of multiplication, summing and setup; a last stage saturates and registers
// the result.
`default_nettype none
module complex_arithmetic_unit #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [1:0]           in_command,
  input  wire logic [WORD_BITS-1:0] in_a_re,
  input  wire logic [WORD_BITS-1:0] in_a_im,
  input  wire logic [WORD_BITS-1:0] in_b_re,
  input  wire logic [WORD_BITS-1:0] in_b_im,
  output logic                      out_valid,
  output logic [WORD_BITS-1:0]      out_res_re,
  output logic [WORD_BITS-1:0]      out_res_im,
  output logic                      out_overflow,
  output logic                      out_div_by_zero
);
  localparam int W  = WORD_BITS;
  localparam int NA = 2 * W + 1;
  localparam int MW = 2 * W;
  localparam int Q  = W + 1;

  cau_pkg::ctl_t  ctl_p [0:Q];
  cau_pkg::lane_t lre_p [0:Q];
  cau_pkg::lane_t lim_p [0:Q];
  logic [NA-1:0]  n_re_p [0:Q];
  logic [NA-1:0]  n_im_p [0:Q];
  logic [MW-1:0]  m_p    [0:Q];
  logic [MW-1:0]  rre_p  [0:Q];
  logic [MW-1:0]  rim_p  [0:Q];
  logic [Q-1:0]   qre_p  [0:Q];
  logic [Q-1:0]   qim_p  [0:Q];
  logic [Q-1:0]   lore_p [0:Q];
  logic [Q-1:0]   loim_p [0:Q];

  assign busy     = 1'b0;
  assign qre_p[0] = '0;
  assign qim_p[0] = '0;

  cau_front #(.W(W), .F(FRAC_BITS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (start & ~busy),
    .in_cmd   (cau_pkg::cmd_t'(in_command)),
    .a_re     (in_a_re),
    .a_im     (in_a_im),
    .b_re     (in_b_re),
    .b_im     (in_b_im),
    .ctl_o    (ctl_p[0]),
    .n_re_o   (n_re_p[0]),
    .n_im_o   (n_im_p[0]),
    .m_o      (m_p[0]),
    .lre_o    (lre_p[0]),
    .lim_o    (lim_p[0]),
    .rem_re_o (rre_p[0]),
    .rem_im_o (rim_p[0]),
    .low_re_o (lore_p[0]),
    .low_im_o (loim_p[0])
  );

  for (genvar k = 0; k < Q; k++) begin : g_div
    logic [NA-1:0]  n_re_r, n_im_r;
    logic [MW-1:0]  m_r;
    cau_pkg::lane_t lre_r, lim_r;
    cau_pkg::ctl_t  ctl_r;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r <= '0;
      end else begin
        ctl_r <= ctl_p[k];
      end
    end

    always_ff @(posedge clk) begin
      n_re_r <= n_re_p[k];
      n_im_r <= n_im_p[k];
      m_r    <= m_p[k];
      lre_r  <= lre_p[k];
      lim_r  <= lim_p[k];
    end

    assign ctl_p[k+1]  = ctl_r;
    assign n_re_p[k+1] = n_re_r;
    assign n_im_p[k+1] = n_im_r;
    assign m_p[k+1]    = m_r;
    assign lre_p[k+1]  = lre_r;
    assign lim_p[k+1]  = lim_r;

    cau_div_step #(.MW(MW), .Q(Q)) u_re (
      .clk   (clk),
      .m_i   (m_p[k]),
      .rem_i (rre_p[k]),
      .quo_i (qre_p[k]),
      .low_i (lore_p[k]),
      .rem_o (rre_p[k+1]),
      .quo_o (qre_p[k+1]),
      .low_o (lore_p[k+1])
    );

    cau_div_step #(.MW(MW), .Q(Q)) u_im (
      .clk   (clk),
      .m_i   (m_p[k]),
      .rem_i (rim_p[k]),
      .quo_i (qim_p[k]),
      .low_i (loim_p[k]),
      .rem_o (rim_p[k+1]),
      .quo_o (qim_p[k+1]),
      .low_o (loim_p[k+1])
    );
  end

  cau_sat #(.W(W), .F(FRAC_BITS)) u_sat (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl_i       (ctl_p[Q]),
    .n_re        (n_re_p[Q]),
    .n_im        (n_im_p[Q]),
    .lre         (lre_p[Q]),
    .lim         (lim_p[Q]),
    .q_re        (qre_p[Q]),
    .q_im        (qim_p[Q]),
    .r_re        (rre_p[Q]),
    .r_im        (rim_p[Q]),
    .out_valid   (out_valid),
    .res_re      (out_res_re),
    .res_im      (out_res_im),
    .overflow    (out_overflow),
    .div_by_zero (out_div_by_zero)
  );
endmodule
`default_nettype wire

>>> hdl/cau_front.sv
// Front end: products, numerator and divisor sums, magnitudes and divider setup.
// Four register stages; depends on cau_pkg.
`default_nettype none
module cau_front #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_vld,
  input  wire cau_pkg::cmd_t     in_cmd,
  input  wire logic [W-1:0]      a_re,
  input  wire logic [W-1:0]      a_im,
  input  wire logic [W-1:0]      b_re,
  input  wire logic [W-1:0]      b_im,
  output cau_pkg::ctl_t          ctl_o,
  output logic [2*W:0]           n_re_o,
  output logic [2*W:0]           n_im_o,
  output logic [2*W-1:0]         m_o,
  output cau_pkg::lane_t         lre_o,
  output cau_pkg::lane_t         lim_o,
  output logic [2*W-1:0]         rem_re_o,
  output logic [2*W-1:0]         rem_im_o,
  output logic [W:0]             low_re_o,
  output logic [W:0]             low_im_o
);
  localparam int NA = 2 * W + 1;
  localparam int MW = 2 * W;
  localparam int Q  = W + 1;
  localparam int NW = NA + F;
  localparam int TW = NW - Q;
  localparam int CW = (TW > MW) ? TW : MW;

  cau_pkg::ctl_t c1_r, c2_r, c3_r, c4_r;
  cau_pkg::ctl_t c1_nxt, c2_nxt;

  logic signed [MW-1:0] ac_r, bd_r, bc_r, ad_r, cc_r, dd_r;
  logic [W:0]           as_re_r, as_im_r;
  logic [NA-1:0]        n_re2_r, n_im2_r, n_re2_nxt, n_im2_nxt;
  logic [MW-1:0]        m2_r, m2_nxt;
  logic [NA-1:0]        n_re3_r, n_im3_r, ab_re3_r, ab_im3_r;
  logic [MW-1:0]        m3_r;
  logic                 ng_re3_r, ng_im3_r;
  logic [NA-1:0]        n_re4_r, n_im4_r;
  logic [MW-1:0]        m4_r;
  cau_pkg::lane_t       lre4_r, lim4_r;
  logic [MW-1:0]        rem_re4_r, rem_im4_r;
  logic [Q-1:0]         low_re4_r, low_im4_r;
  logic [NW-1:0]        nf_re, nf_im;
  logic [TW-1:0]        top_re, top_im;

  always_comb begin
    c1_nxt     = '0;
    c1_nxt.vld = in_vld;
    c1_nxt.cmd = in_cmd;
    c2_nxt     = c1_r;
    m2_nxt     = MW'($unsigned(cc_r)) + MW'($unsigned(dd_r));
    case (c1_r.cmd)
      cau_pkg::CMD_MUL: begin
        n_re2_nxt = {ac_r[MW-1], ac_r} - {bd_r[MW-1], bd_r};
        n_im2_nxt = {bc_r[MW-1], bc_r} + {ad_r[MW-1], ad_r};
      end
      cau_pkg::CMD_DIV: begin
        n_re2_nxt = {ac_r[MW-1], ac_r} + {bd_r[MW-1], bd_r};
        n_im2_nxt = {bc_r[MW-1], bc_r} - {ad_r[MW-1], ad_r};
      end
      default: begin
        n_re2_nxt = {{(NA-W-1){as_re_r[W]}}, as_re_r};
        n_im2_nxt = {{(NA-W-1){as_im_r[W]}}, as_im_r};
      end
    endcase
    c2_nxt.dz = (c1_r.cmd == cau_pkg::CMD_DIV) && (m2_nxt == '0);
    nf_re  = NW'(ab_re3_r) << F;
    nf_im  = NW'(ab_im3_r) << F;
    top_re = nf_re[NW-1:Q];
    top_im = nf_im[NW-1:Q];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r <= '0;
      c2_r <= '0;
      c3_r <= '0;
      c4_r <= '0;
    end else begin
      c1_r <= c1_nxt;
      c2_r <= c2_nxt;
      c3_r <= c2_r;
      c4_r <= c3_r;
    end
  end

  always_ff @(posedge clk) begin
    ac_r <= $signed(a_re) * $signed(b_re);
    bd_r <= $signed(a_im) * $signed(b_im);
    bc_r <= $signed(a_im) * $signed(b_re);
    ad_r <= $signed(a_re) * $signed(b_im);
    cc_r <= $signed(b_re) * $signed(b_re);
    dd_r <= $signed(b_im) * $signed(b_im);
    if (in_cmd == cau_pkg::CMD_SUB) begin
      as_re_r <= {a_re[W-1], a_re} - {b_re[W-1], b_re};
      as_im_r <= {a_im[W-1], a_im} - {b_im[W-1], b_im};
    end else begin
      as_re_r <= {a_re[W-1], a_re} + {b_re[W-1], b_re};
      as_im_r <= {a_im[W-1], a_im} + {b_im[W-1], b_im};
    end
    n_re2_r  <= n_re2_nxt;
    n_im2_r  <= n_im2_nxt;
    m2_r     <= m2_nxt;
    n_re3_r  <= n_re2_r;
    n_im3_r  <= n_im2_r;
    m3_r     <= m2_r;
    ng_re3_r <= n_re2_r[NA-1];
    ng_im3_r <= n_im2_r[NA-1];
    ab_re3_r <= n_re2_r[NA-1] ? (~n_re2_r + NA'(1)) : n_re2_r;
    ab_im3_r <= n_im2_r[NA-1] ? (~n_im2_r + NA'(1)) : n_im2_r;
    n_re4_r    <= n_re3_r;
    n_im4_r    <= n_im3_r;
    m4_r       <= m3_r;
    lre4_r.neg <= ng_re3_r;
    lim4_r.neg <= ng_im3_r;
    lre4_r.hi  <= CW'(top_re) >= CW'(m3_r);
    lim4_r.hi  <= CW'(top_im) >= CW'(m3_r);
    rem_re4_r  <= MW'(top_re);
    rem_im4_r  <= MW'(top_im);
    low_re4_r  <= nf_re[Q-1:0];
    low_im4_r  <= nf_im[Q-1:0];
  end

  assign ctl_o    = c4_r;
  assign n_re_o   = n_re4_r;
  assign n_im_o   = n_im4_r;
  assign m_o      = m4_r;
  assign lre_o    = lre4_r;
  assign lim_o    = lim4_r;
  assign rem_re_o = rem_re4_r;
  assign rem_im_o = rem_im4_r;
  assign low_re_o = low_re4_r;
  assign low_im_o = low_im4_r;
endmodule
`default_nettype wire

>>> hdl/cau_div_step.sv
// One restoring division step: brings in one numerator bit and yields one quotient bit.
// Registered outputs; no dependencies.
`default_nettype none
module cau_div_step #(
  parameter int MW = 64,
  parameter int Q  = 33
) (
  input  wire logic          clk,
  input  wire logic [MW-1:0] m_i,
  input  wire logic [MW-1:0] rem_i,
  input  wire logic [Q-1:0]  quo_i,
  input  wire logic [Q-1:0]  low_i,
  output logic [MW-1:0]      rem_o,
  output logic [Q-1:0]       quo_o,
  output logic [Q-1:0]       low_o
);
  logic [MW:0]   sh, diff;
  logic          ge;
  logic [MW-1:0] rem_nxt;

  always_comb begin
    sh      = {rem_i, low_i[Q-1]};
    diff    = sh - {1'b0, m_i};
    ge      = sh >= {1'b0, m_i};
    rem_nxt = ge ? diff[MW-1:0] : sh[MW-1:0];
  end

  always_ff @(posedge clk) begin
    rem_o <= rem_nxt;
    quo_o <= {quo_i[Q-2:0], ge};
    low_o <= {low_i[Q-2:0], 1'b0};
  end
endmodule
`default_nettype wire

>>> hdl/cau_sat.sv
// Output stage: quotient sign fix, product scaling, saturation and flags.
// Holds the output register; depends on cau_pkg.
`default_nettype none
module cau_sat #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire cau_pkg::ctl_t  ctl_i,
  input  wire logic [2*W:0]   n_re,
  input  wire logic [2*W:0]   n_im,
  input  wire cau_pkg::lane_t lre,
  input  wire cau_pkg::lane_t lim,
  input  wire logic [W:0]     q_re,
  input  wire logic [W:0]     q_im,
  input  wire logic [2*W-1:0] r_re,
  input  wire logic [2*W-1:0] r_im,
  output logic                out_valid,
  output logic [W-1:0]        res_re,
  output logic [W-1:0]        res_im,
  output logic                overflow,
  output logic                div_by_zero
);
  localparam int NA = 2 * W + 1;
  localparam int Q  = W + 1;
  localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

  function automatic logic [W:0] div_lane(cau_pkg::lane_t l, logic [Q-1:0] q, logic rnz);
    logic [Q:0] t;
    logic [W:0] r;
    t = {1'b0, q} + (Q+1)'(rnz);
    if (l.hi) begin
      r = {1'b1, l.neg ? MINV : MAXV};
    end else if (l.neg) begin
      if (t > ((Q+1)'(1) << (W-1))) r = {1'b1, MINV};
      else r = {1'b0, W'(~t + (Q+1)'(1))};
    end else if ({1'b0, q} > (Q+1)'(MAXV)) begin
      r = {1'b1, MAXV};
    end else begin
      r = {1'b0, q[W-1:0]};
    end
    return r;
  endfunction

  function automatic logic [W:0] fix_lane(logic [NA-1:0] n, logic mul);
    logic [NA-1:0] x;
    logic          fits;
    x    = mul ? NA'($signed(n) >>> F) : n;
    fits = (&x[NA-1:W-1]) | ~(|x[NA-1:W-1]);
    return fits ? {1'b0, x[W-1:0]} : {1'b1, x[NA-1] ? MINV : MAXV};
  endfunction

  logic [W:0]   lre_v, lim_v;
  logic [W-1:0] res_re_nxt, res_im_nxt;
  logic         ovf_nxt;
  logic         vld_r, ovf_r, dz_r;
  logic [W-1:0] res_re_r, res_im_r;

  always_comb begin
    if (ctl_i.cmd == cau_pkg::CMD_DIV) begin
      lre_v = div_lane(lre, q_re, |r_re);
      lim_v = div_lane(lim, q_im, |r_im);
    end else begin
      lre_v = fix_lane(n_re, ctl_i.cmd == cau_pkg::CMD_MUL);
      lim_v = fix_lane(n_im, ctl_i.cmd == cau_pkg::CMD_MUL);
    end
    if (ctl_i.dz) begin
      res_re_nxt = '0;
      res_im_nxt = '0;
      ovf_nxt    = 1'b0;
    end else begin
      res_re_nxt = lre_v[W-1:0];
      res_im_nxt = lim_v[W-1:0];
      ovf_nxt    = lre_v[W] | lim_v[W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= ctl_i.vld;
    end
  end

  always_ff @(posedge clk) begin
    res_re_r <= res_re_nxt;
    res_im_r <= res_im_nxt;
    ovf_r    <= ovf_nxt;
    dz_r     <= ctl_i.dz;
  end

  assign out_valid   = vld_r;
  assign res_re      = res_re_r;
  assign res_im      = res_im_r;
  assign overflow    = ovf_r;
  assign div_by_zero = dz_r;
endmodule
`default_nettype wire

>>> test/complex_arithmetic_unit_tb.sv
// Testbench for the complex arithmetic unit: drives random and corner-case words and
// checks every result against a built-in arithmetic predictor.
// Depends on cau_pkg and complex_arithmetic_unit.
`timescale 1ns / 100ps
module complex_arithmetic_unit_tb;

  localparam int WB = 32;
  localparam int FB = 16;
  localparam int LAT = WB + 6;
  localparam int WATCHDOG = 2000;
  localparam logic signed [WB-1:0] WMAX = {1'b0, {(WB-1){1'b1}}};
  localparam logic signed [WB-1:0] WMIN = {1'b1, {(WB-1){1'b0}}};

  typedef struct {
    cau_pkg::cmd_t cmd;
    logic signed [WB-1:0] a_re;
    logic signed [WB-1:0] a_im;
    logic signed [WB-1:0] b_re;
    logic signed [WB-1:0] b_im;
  } op_word_t;

  typedef struct {
    logic [WB-1:0] re;
    logic [WB-1:0] im;
    logic ovf;
    logic dz;
  } res_word_t;

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic [1:0] in_command = '0;
  logic [WB-1:0] in_a_re = '0, in_a_im = '0, in_b_re = '0, in_b_im = '0;
  wire busy, out_valid, out_overflow, out_div_by_zero;
  wire [WB-1:0] out_res_re, out_res_im;

  complex_arithmetic_unit #(.WORD_BITS(WB), .FRAC_BITS(FB)) u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_command(in_command), .in_a_re(in_a_re), .in_a_im(in_a_im),
    .in_b_re(in_b_re), .in_b_im(in_b_im), .out_valid(out_valid),
    .out_res_re(out_res_re), .out_res_im(out_res_im),
    .out_overflow(out_overflow), .out_div_by_zero(out_div_by_zero)
  );

  op_word_t pending_words[$];
  res_word_t expected_results[$];
  int sender_idle_pct = 0;
  bit hold_sender = 0;
  bit stim_done = 0;
  int errors = 0;
  int quiet_cycles = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [WB-1:0] clamp(input logic signed [199:0] x, inout logic ovf);
    if (x > 200'(signed'(WMAX))) begin
      ovf = 1;
      return WMAX;
    end
    if (x < 200'(signed'(WMIN))) begin
      ovf = 1;
      return WMIN;
    end
    return x[WB-1:0];
  endfunction

  // Floor division of n * 2^FB by a positive m.
  function automatic logic signed [199:0] floor_quot(input logic signed [199:0] n,
                                                     input logic signed [199:0] m);
    logic signed [199:0] num, q;
    num = n <<< FB;
    q = num / m;
    if ((num % m != 0) && (num < 0)) q = q - 1;
    return q;
  endfunction

  function automatic res_word_t complex_result(input op_word_t w);
    logic signed [199:0] a, b, c, d, re, im, mag;
    res_word_t r;
    logic ovf;
    a = w.a_re;
    b = w.a_im;
    c = w.b_re;
    d = w.b_im;
    ovf = 0;
    r.dz = 0;
    case (w.cmd)
      cau_pkg::CMD_ADD: begin
        re = a + c;
        im = b + d;
      end
      cau_pkg::CMD_SUB: begin
        re = a - c;
        im = b - d;
      end
      cau_pkg::CMD_MUL: begin
        re = (a * c - b * d) >>> FB;
        im = (b * c + a * d) >>> FB;
      end
      default: begin
        mag = c * c + d * d;
        if (mag == 0) begin
          r.dz = 1;
          re = 0;
          im = 0;
        end else begin
          re = floor_quot(a * c + b * d, mag);
          im = floor_quot(b * c - a * d, mag);
        end
      end
    endcase
    r.re = clamp(re, ovf);
    r.im = clamp(im, ovf);
    r.ovf = ovf;
    return r;
  endfunction

  function automatic logic [WB-1:0] rand_operand();
    case ($urandom_range(0, 9))
      0: return WMAX;
      1: return WMIN;
      2: return '0;
      3: return WB'(signed'($urandom_range(0, 8)) - 4) <<< FB;
      4: return WB'(signed'($urandom_range(0, 2000)) - 1000);
      5, 6: return WB'(signed'($urandom_range(0, 1 << 20)) - (1 << 19));
      default: return $urandom;
    endcase
  endfunction

  task automatic push_word(input cau_pkg::cmd_t c, input logic [WB-1:0] ar, ai, br, bi);
    op_word_t w;
    w.cmd = c;
    w.a_re = ar;
    w.a_im = ai;
    w.b_re = br;
    w.b_im = bi;
    pending_words.push_back(w);
  endtask

  task automatic wait_drained();
    while (pending_words.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    hold_sender = 1;
    while (expected_results.size() != 0) @(posedge clk);
    hold_sender = 0;
  endtask

  // Driver.
  always @(posedge clk) begin
    if (rst_n && pending_words.size() != 0 && !hold_sender && !busy &&
        !(start && busy) && $urandom_range(0, 99) >= sender_idle_pct) begin
      op_word_t w;
      w = pending_words.pop_front();
      start <= 1;
      in_command <= w.cmd;
      in_a_re <= w.a_re;
      in_a_im <= w.a_im;
      in_b_re <= w.b_re;
      in_b_im <= w.b_im;
    end else if (!(start && busy)) begin
      start <= 0;
      in_command <= 2'($urandom);
      in_a_re <= $urandom;
    end
  end

  // Prediction at acceptance, checking of results.
  always @(posedge clk) begin
    if (rst_n && start && !busy) begin
      op_word_t w;
      w.cmd = cau_pkg::cmd_t'(in_command);
      w.a_re = in_a_re;
      w.a_im = in_a_im;
      w.b_re = in_b_re;
      w.b_im = in_b_im;
      expected_results.push_back(complex_result(w));
    end
    if (rst_n && out_valid) begin
      res_word_t e;
      if (expected_results.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (out_res_re !== e.re) begin
          $error("res_re expected %h actual %h", e.re, out_res_re);
          errors++;
        end
        if (out_res_im !== e.im) begin
          $error("res_im expected %h actual %h", e.im, out_res_im);
          errors++;
        end
        if (out_overflow !== e.ovf) begin
          $error("overflow expected %b actual %b", e.ovf, out_overflow);
          errors++;
        end
        if (out_div_by_zero !== e.dz) begin
          $error("div_by_zero expected %b actual %b", e.dz, out_div_by_zero);
          errors++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || stim_done) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int k;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    for (int c = 0; c < 4; c++) begin
      push_word(cau_pkg::cmd_t'(c), WMAX, WMAX, WMAX, WMAX);
      push_word(cau_pkg::cmd_t'(c), WMIN, WMIN, WMIN, WMIN);
      push_word(cau_pkg::cmd_t'(c), WMAX, WMIN, WMIN, WMAX);
      push_word(cau_pkg::cmd_t'(c), 32'h0001_8000, 32'hFFFE_0000, 32'h0000_0001,
                32'hFFFF_FFFF);
    end
    push_word(cau_pkg::CMD_DIV, 32'h0001_0000, 32'h0002_0000, '0, '0);
    push_word(cau_pkg::CMD_DIV, WMIN, WMAX, '0, 32'h0000_0001);
    push_word(cau_pkg::CMD_DIV, 32'hFFFF_FFFF, '0, 32'h0003_0000, '0);
    push_word(cau_pkg::CMD_MUL, 32'hFFFF_FFFF, '0, 32'h0000_0001, '0);
    push_word(cau_pkg::CMD_DIV, '0, '0, '0, '0);
    wait_drained();
    for (int phase = 0; phase < 3; phase++) begin
      sender_idle_pct = (phase == 0) ? 33 : (phase == 1) ? 56 : 0;
      for (k = 0; k < 550; k++) begin
        cau_pkg::cmd_t c;
        logic [WB-1:0] br, bi;
        c = cau_pkg::cmd_t'($urandom_range(0, 3));
        br = rand_operand();
        bi = rand_operand();
        if (c == cau_pkg::CMD_DIV && $urandom_range(0, 19) == 0) begin
          br = '0;
          bi = '0;
        end
        push_word(c, rand_operand(), rand_operand(), br, bi);
        if (k % 100 == 99 && phase != 2) begin
          while (pending_words.size() != 0) @(posedge clk);
        end
      end
      wait_drained();
    end
    stim_done = 1;
    repeat (LAT + 10) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
